// ===== sv/fpr_pkg.sv =====
// fpr_pkg: shared types and constants of the framed pose record parser
// no dependencies; compile first

package fpr_pkg;

  // frame layout
  localparam int PAYLOAD_BYTES = 24;
  localparam int WORD_BYTES    = 4;
  localparam int WORD_COUNT    = PAYLOAD_BYTES / WORD_BYTES;
  localparam int INDEX_W       = $clog2(PAYLOAD_BYTES);

  // delimiter bytes
  localparam logic [7:0] HDR_CR = 8'h0D;
  localparam logic [7:0] HDR_LF = 8'h0A;

  typedef logic [7:0]  byte_t;
  typedef logic [31:0] word_t;

  // sequencer to datapath controls
  typedef struct packed {
    logic shift;      // move the received byte into the cell chain
    logic emit;       // trailer complete: capture the record
    logic at_last;    // waiting for the final trailer byte
  } seq_ctl_t;

endpackage

// ===== sv/fpr_if.sv =====
// fpr_if: valid/ready channel interfaces for received bytes and pose records
// depends on fpr_pkg

interface fpr_byte_if;
  import fpr_pkg::*;

  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fpr_pose_if;
  import fpr_pkg::*;

  logic  valid;
  logic  ready;
  word_t yaw_bits;
  word_t pitch_bits;
  word_t roll_bits;
  word_t pos_x_bits;
  word_t pos_y_bits;
  word_t yaw_rate_bits;

  modport source (output valid, output yaw_bits, output pitch_bits, output roll_bits,
                  output pos_x_bits, output pos_y_bits, output yaw_rate_bits, input ready);
  modport sink   (input valid, input yaw_bits, input pitch_bits, input roll_bits,
                  input pos_x_bits, input pos_y_bits, input yaw_rate_bits, output ready);
endinterface

// ===== sv/fpr_cell.sv =====
// fpr_cell: one byte cell of the payload chain, loads from its upstream neighbor on shift
// depends on fpr_pkg

module fpr_cell (
  input  logic          clk,
  input  logic          shift,
  input  fpr_pkg::byte_t d,
  output fpr_pkg::byte_t q
);
  import fpr_pkg::*;

  byte_t data;

  // payload holding register, no reset needed
  always_ff @(posedge clk) begin
    if (shift) begin
      data <= d;
    end
  end

  assign q = data;

endmodule

// ===== sv/fpr_seq.sv =====
// fpr_seq: frame sequencer, hunts header, counts payload bytes, checks trailer
// depends on fpr_pkg

module fpr_seq (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  fpr_pkg::byte_t   rx_byte,
  output fpr_pkg::seq_ctl_t ctl
);
  import fpr_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LF,
    PH_PAYLOAD,
    PH_TR_LF,
    PH_TR_CR
  } phase_t;

  phase_t               phase;
  logic [INDEX_W-1:0]   byte_index;

  // phase and payload counter
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      byte_index <= '0;
    end else if (accept) begin
      unique case (phase)
        PH_HUNT: begin
          if (rx_byte == HDR_CR) phase <= PH_LF;
        end
        PH_LF: begin
          if (rx_byte == HDR_LF) begin
            phase      <= PH_PAYLOAD;
            byte_index <= '0;
          end else if (rx_byte != HDR_CR) begin
            phase <= PH_HUNT;
          end
        end
        PH_PAYLOAD: begin
          if (byte_index == INDEX_W'(PAYLOAD_BYTES - 1)) begin
            phase      <= PH_TR_LF;
            byte_index <= '0;
          end else begin
            byte_index <= byte_index + 1'b1;
          end
        end
        PH_TR_LF: begin
          phase <= (rx_byte == HDR_LF) ? PH_TR_CR : PH_HUNT;
        end
        PH_TR_CR: begin
          phase <= PH_HUNT;
        end
        default: begin
          phase <= PH_HUNT;
        end
      endcase
    end
  end

  // controls to the chain and output stage
  always_comb begin
    ctl.shift   = accept && (phase == PH_PAYLOAD);
    ctl.emit    = accept && (phase == PH_TR_CR) && (rx_byte == HDR_CR);
    ctl.at_last = (phase == PH_TR_CR);
  end

endmodule

// ===== sv/framed_pose_record_parser_top.sv =====
// framed pose record parser, top level: sequencer, payload cell chain, output register
// depends on fpr_pkg, fpr_if, fpr_cell, fpr_seq
//
// Usage:
//   byte_in carries one received byte per word (rx_byte). A frame is 0x0D 0x0A,
//   24 payload bytes, 0x0A 0x0D; extra 0x0D bytes before the header 0x0A are skipped
//   and any wrong delimiter byte restarts the header hunt.
//   pose_out carries one word per complete frame: six 32-bit fields, each taken
//   little-endian from four payload bytes, passed on as raw float bit patterns.
// Throughput: one byte per cycle unless stalled. Payload bytes shift through a row of
//   24 byte cells, one cell step per accepted byte, so the chain never holds up input.
// Output: the record appears on pose_out in the cycle after the final trailer byte
//   is accepted, held in an output register.
// Stall: while a record waits in the output register, bytes keep flowing; only the
//   final trailer byte of the next frame is held off until the record is taken.
// Reset (rst, synchronous): back to header hunt, output register empty.

module framed_pose_record_parser_top (
  input  logic              clk,
  input  logic              rst,
  fpr_byte_if.sink          byte_in,
  fpr_pose_if.source        pose_out
);
  import fpr_pkg::*;

  seq_ctl_t ctl;
  logic     accept;
  byte_t    chain [PAYLOAD_BYTES + 1];
  word_t    words [WORD_COUNT];
  word_t    rec   [WORD_COUNT];
  logic     rec_valid;

  // a byte is held only when it is the final trailer byte and the output is full and not being taken
  assign byte_in.ready = !ctl.at_last || !rec_valid || pose_out.ready;
  assign accept        = byte_in.valid && byte_in.ready;

  fpr_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (byte_in.rx_byte),
    .ctl     (ctl)
  );

  // payload chain: newest byte enters at cell 0, payload byte 0 ends at the far end
  assign chain[0] = byte_in.rx_byte;

  for (genvar i = 0; i < PAYLOAD_BYTES; i++) begin : g_cell
    fpr_cell u_cell (
      .clk   (clk),
      .shift (ctl.shift),
      .d     (chain[i]),
      .q     (chain[i + 1])
    );
  end

  // assemble little-endian words from the chain taps
  always_comb begin
    for (int j = 0; j < WORD_COUNT; j++) begin
      for (int b = 0; b < WORD_BYTES; b++) begin
        words[j][8*b +: 8] = chain[PAYLOAD_BYTES - (WORD_BYTES * j + b)];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (ctl.emit) begin
      rec_valid <= 1'b1;
    end else if (pose_out.ready) begin
      rec_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      rec <= words;
    end
  end

  assign pose_out.valid         = rec_valid;
  assign pose_out.yaw_bits      = rec[0];
  assign pose_out.pitch_bits    = rec[1];
  assign pose_out.roll_bits     = rec[2];
  assign pose_out.pos_x_bits    = rec[3];
  assign pose_out.pos_y_bits    = rec[4];
  assign pose_out.yaw_rate_bits = rec[5];

endmodule

// ===== test/framed_pose_record_parser_top_tb.sv =====
`timescale 1ns / 1ps
// testbench for framed_pose_record_parser_top: byte stream of good and damaged frames in,
// pose records checked against a deframing tracker; depends on fpr_pkg, fpr_if and the RTL

module framed_pose_record_parser_top_tb;
  import fpr_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int BYTE_TARGET  = 1600;
  localparam int HOLD_CYCLES  = 250;
  localparam int LIMIT_CYCLES = 200_000;

  // deframing phases, in the order the frame is walked
  typedef enum logic [2:0] {
    PH_HUNT     = 3'd0,
    PH_AWAIT_LF = 3'd1,
    PH_PAYLOAD  = 3'd2,
    PH_TRAIL_LF = 3'd3,
    PH_TRAIL_CR = 3'd4
  } frame_phase_t;

  typedef enum {
    FRAME_GOOD,
    FRAME_BAD_HEADER,
    FRAME_BAD_TRAIL_LF,
    FRAME_BAD_TRAIL_CR
  } frame_kind_t;

  typedef struct packed {
    word_t yaw, pitch, roll, pos_x, pos_y, yaw_rate;
  } pose_rec_t;

  // tracks the frame state of the byte stream and the records it should yield
  class pose_frame_tracker;
    frame_phase_t phase;
    logic [4:0]   slot;
    byte_t        payload [PAYLOAD_BYTES];
    pose_rec_t    expected_records [$];
    int           mismatches;
    int           records_checked;

    function new();
      phase = PH_HUNT;
      slot = '0;
      foreach (payload[i]) payload[i] = '0;
      mismatches = 0;
      records_checked = 0;
    endfunction

    function word_t word_at(int base);
      return {payload[base + 3], payload[base + 2], payload[base + 1], payload[base]};
    endfunction

    // advance the frame state by one accepted byte
    function void take_byte(byte_t b);
      pose_rec_t rec;
      case (phase)
        PH_HUNT: begin
          if (b == HDR_CR) phase = PH_AWAIT_LF;
        end
        PH_AWAIT_LF: begin
          if (b == HDR_LF) begin
            slot = '0;
            phase = PH_PAYLOAD;
          end else if (b != HDR_CR) begin
            phase = PH_HUNT;
          end
        end
        PH_PAYLOAD: begin
          if (slot < PAYLOAD_BYTES) payload[slot] = b;
          slot = slot + 5'd1;
          if (slot >= PAYLOAD_BYTES || slot == 0) begin
            slot = '0;
            phase = PH_TRAIL_LF;
          end
        end
        PH_TRAIL_LF: begin
          phase = (b == HDR_LF) ? PH_TRAIL_CR : PH_HUNT;
        end
        PH_TRAIL_CR: begin
          if (b == HDR_CR) begin
            rec.yaw      = word_at(0);
            rec.pitch    = word_at(4);
            rec.roll     = word_at(8);
            rec.pos_x    = word_at(12);
            rec.pos_y    = word_at(16);
            rec.yaw_rate = word_at(20);
            expected_records.push_back(rec);
          end
          phase = PH_HUNT;
        end
        default: begin
          phase = PH_HUNT;
        end
      endcase
    endfunction

    function void compare_field(string name, word_t want, word_t got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: record %0d %s mismatch: expected %08h, got %08h",
                   $realtime, records_checked, name, want, got);
      end
    endfunction

    // compare one accepted record with the oldest expected one
    function void check_record(pose_rec_t got);
      pose_rec_t want;
      if (expected_records.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected record, yaw %08h", $realtime, got.yaw);
      end else begin
        want = expected_records.pop_front();
        compare_field("yaw_bits", want.yaw, got.yaw);
        compare_field("pitch_bits", want.pitch, got.pitch);
        compare_field("roll_bits", want.roll, got.roll);
        compare_field("pos_x_bits", want.pos_x, got.pos_x);
        compare_field("pos_y_bits", want.pos_y, got.pos_y);
        compare_field("yaw_rate_bits", want.yaw_rate, got.yaw_rate);
      end
      records_checked++;
    endfunction

    function int pending();
      return expected_records.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  fpr_byte_if byte_ch ();
  fpr_pose_if pose_ch ();

  framed_pose_record_parser_top DUT (
    .clk      (clk),
    .rst      (rst),
    .byte_in  (byte_ch),
    .pose_out (pose_ch)
  );

  pose_frame_tracker tracker;
  int  bytes_sent;
  bit  sender_quiet;
  bit  receiver_quiet;

  // clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // run limit
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("== FAIL ==");
    $finish;
  end

  // byte with extra weight on delimiters and extremes
  function automatic byte_t pick_byte();
    int r;
    r = $urandom_range(99);
    if (r < 10) return HDR_CR;
    if (r < 20) return HDR_LF;
    if (r < 25) return 8'h00;
    if (r < 30) return 8'hFF;
    return byte_t'($urandom_range(255));
  endfunction

  // offer one byte at a falling edge, wait for it to be taken, return at a falling edge
  task automatic send_byte(byte_t b);
    while (!sender_quiet && $urandom_range(99) < 8) begin
      byte_ch.valid <= 1'b0;
      @(negedge clk);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.rx_byte <= b;
    do @(posedge clk); while (!byte_ch.ready);
    tracker.take_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  // one frame, possibly damaged at the header or trailer
  task automatic send_frame(frame_kind_t kind, int extra_cr, bit fixed_payload);
    byte_t b;
    send_byte(HDR_CR);
    repeat (extra_cr) send_byte(HDR_CR);
    if (kind == FRAME_BAD_HEADER) begin
      b = pick_byte();
      if (b == HDR_LF || b == HDR_CR) b = b ^ 8'h10;
      send_byte(b);
      return;
    end
    send_byte(HDR_LF);
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      // fixed pattern walks through zero, all ones and both delimiters
      if (fixed_payload)
        b = (i % 4 == 0) ? 8'h00 : (i % 4 == 1) ? 8'hFF : (i % 4 == 2) ? HDR_CR : HDR_LF;
      else
        b = pick_byte();
      send_byte(b);
    end
    if (kind == FRAME_BAD_TRAIL_LF) begin
      b = pick_byte();
      if (b == HDR_LF) b = b ^ 8'h01;
      send_byte(b);
      return;
    end
    send_byte(HDR_LF);
    if (kind == FRAME_BAD_TRAIL_CR) begin
      b = pick_byte();
      if (b == HDR_CR) b = b ^ 8'h01;
      send_byte(b);
    end else begin
      send_byte(HDR_CR);
    end
  endtask

  // record sink: random stalls, two long hold-offs, a stretch with no stalls
  initial begin
    int holds_done;
    holds_done = 0;
    pose_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst && holds_done < 2 && tracker.records_checked >= (holds_done == 0 ? 3 : 30))
      begin
        pose_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        holds_done++;
      end else begin
        receiver_quiet = (tracker.records_checked >= 12 && tracker.records_checked < 24);
        pose_ch.ready <= receiver_quiet || ($urandom_range(99) >= 8);
      end
    end
  end

  // check each accepted record
  always @(posedge clk) begin
    pose_rec_t got;
    if (!rst && pose_ch.valid && pose_ch.ready) begin
      got.yaw      = pose_ch.yaw_bits;
      got.pitch    = pose_ch.pitch_bits;
      got.roll     = pose_ch.roll_bits;
      got.pos_x    = pose_ch.pos_x_bits;
      got.pos_y    = pose_ch.pos_y_bits;
      got.yaw_rate = pose_ch.yaw_rate_bits;
      tracker.check_record(got);
    end
  end

  // main sequence
  initial begin
    int r;
    bit drained;
    tracker = new();
    bytes_sent = 0;
    sender_quiet = 1'b0;
    drained = 1'b0;
    byte_ch.valid = 1'b0;
    byte_ch.rx_byte = '0;
    rst = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: stray bytes in the hunt, repeated header start, broken header,
    // then a good frame of extreme payload bytes
    send_byte(HDR_LF);
    send_byte(8'hFF);
    send_byte(HDR_CR);
    send_byte(8'h00);
    send_frame(FRAME_GOOD, 2, 1'b1);

    // random frames, mostly well formed, with damaged ones and noise between
    while (bytes_sent < BYTE_TARGET) begin
      sender_quiet = (bytes_sent >= 400 && bytes_sent < 700);
      if (!drained && bytes_sent >= 900) begin
        // pause until every record is out
        byte_ch.valid <= 1'b0;
        do @(negedge clk); while (tracker.pending() != 0);
        drained = 1'b1;
      end
      r = $urandom_range(99);
      if (r < 75)
        send_frame(FRAME_GOOD, ($urandom_range(99) < 70) ? 0 : $urandom_range(3, 1), 1'b0);
      else if (r < 81)
        send_frame(FRAME_BAD_HEADER, $urandom_range(1), 1'b0);
      else if (r < 87)
        send_frame(FRAME_BAD_TRAIL_LF, $urandom_range(1), 1'b0);
      else if (r < 93)
        send_frame(FRAME_BAD_TRAIL_CR, $urandom_range(1), 1'b0);
      else
        repeat ($urandom_range(4, 1)) send_byte(pick_byte());
    end
    byte_ch.valid <= 1'b0;

    // drain, then give a late extra record time to show up
    while (tracker.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (tracker.mismatches == 0 && tracker.pending() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
